// ===== hw/rtl/cvc_pkg.sv =====
// Shared types and constants for the 3x3 convolution block.
package cvc_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int COEF_W        = 14;
    localparam int COEF_ROW_W    = 42;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PROD_W        = 23;
    localparam int SUM_W         = 27;

    localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST = 42'd264241152;
    localparam logic [COEF_ROW_W-1:0] COEF_MID_RST = 42'd4329348022016;
    localparam logic [COEF_ROW_W-1:0] COEF_BOT_RST = 42'd264241152;
    localparam logic [11:0]           FRAME_W_RST  = 12'd640;
    localparam logic [15:0]           FRAME_H_RST  = 16'd480;

    typedef enum logic [2:0] {
        REG_COEF_TOP = 3'd0,
        REG_COEF_MID = 3'd1,
        REG_COEF_BOT = 3'd2,
        REG_FRAME_W  = 3'd3,
        REG_FRAME_H  = 3'd4
    } cfg_reg_t;

    typedef logic [31:0] pixel_t;

    typedef struct packed {
        pixel_t [8:0] win;
        logic [15:0]  row;
        logic [10:0]  col;
        logic         row_end;
        logic         last_row;
    } job_t;

    typedef struct packed {
        logic [7:0]  alpha;
        logic [10:0] col;
        logic [15:0] row;
        logic        run_last;
        logic        frame_end;
    } side_t;

    localparam int JOB_W = $bits(job_t);

endpackage

// ===== hw/rtl/cvc_front.sv =====
// Front end: pixel intake, line stores, window shift and job generation.
module cvc_front #(
    parameter int MAX_WIDTH = cvc_pkg::MAX_WIDTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cvc_pkg::pixel_t s_pixel,
    input  logic [11:0]     frame_width,
    input  logic [15:0]     frame_height,
    output logic            job_valid,
    output cvc_pkg::job_t   job,
    input  logic            job_ready
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

    cvc_pkg::pixel_t older_mem [MAX_WIDTH];
    cvc_pkg::pixel_t newer_mem [MAX_WIDTH];

    logic [10:0]     col_reg, col_next;
    logic [15:0]     row_reg, row_next;
    logic            s1_valid_reg;
    cvc_pkg::pixel_t s1_px_reg;
    logic [AW-1:0]   s1_idx_reg;
    logic [10:0]     s1_col_reg;
    logic [15:0]     s1_row_reg;
    logic            s1_row_end_reg, s1_last_row_reg;
    cvc_pkg::pixel_t rd_older_reg, rd_newer_reg;
    logic            fwd_reg;
    cvc_pkg::pixel_t fwd_older_reg, fwd_newer_reg;
    cvc_pkg::pixel_t [8:0] win_reg, win_next;

    logic [WW-1:0] w_eff, wm1, col_ext, idx_full;
    logic [15:0]   hm1;
    logic [AW-1:0] idx;
    logic          row_end, last_row, acc, s1_adv;
    cvc_pkg::pixel_t older_eff, newer_eff;

    always_comb begin
        if (frame_width == 12'd0) begin
            w_eff = WW'(1);
        end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width);
        end
        wm1      = w_eff - WW'(1);
        col_ext  = WW'(col_reg);
        idx_full = (col_ext < WW'(MAX_WIDTH)) ? col_ext : WW'(MAX_WIDTH - 1);
        idx      = idx_full[AW-1:0];
        row_end  = (col_ext >= wm1);
        hm1      = (frame_height == 16'd0) ? 16'd0 : frame_height - 16'd1;
        last_row = (row_reg >= hm1);
    end

    assign s1_adv  = s1_valid_reg && job_ready;
    assign s_ready = !s1_valid_reg || job_ready;
    assign acc     = s_valid && s_ready;

    always_comb begin
        if (row_end) begin
            col_next = 11'd0;
            row_next = last_row ? 16'd0 : row_reg + 16'd1;
        end else begin
            col_next = col_reg + 11'd1;
            row_next = row_reg;
        end
    end

    // same-address write in the cycle of the read: take the data being written
    assign older_eff = fwd_reg ? fwd_older_reg : rd_older_reg;
    assign newer_eff = fwd_reg ? fwd_newer_reg : rd_newer_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[3*i]   = win_reg[3*i+1];
            win_next[3*i+1] = win_reg[3*i+2];
        end
        win_next[2] = older_eff;
        win_next[5] = newer_eff;
        win_next[8] = s1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            older_mem[s1_idx_reg] <= newer_eff;
            newer_mem[s1_idx_reg] <= s1_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_older_reg <= older_mem[idx];
            rd_newer_reg <= newer_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_px_reg       <= s_pixel;
            s1_idx_reg      <= idx;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= last_row;
            fwd_reg         <= s1_adv && (s1_idx_reg == idx);
            fwd_older_reg   <= newer_eff;
            fwd_newer_reg   <= s1_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= 11'd0;
            row_reg      <= 16'd0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            if (acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_adv) begin
                win_reg <= win_next;
            end
            if (acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    assign job_valid    = s1_valid_reg;
    assign job.win      = win_next;
    assign job.row      = s1_row_reg;
    assign job.col      = s1_col_reg;
    assign job.row_end  = s1_row_end_reg;
    assign job.last_row = s1_last_row_reg;

endmodule

// ===== hw/rtl/cvc_fifo.sv =====
// Small request queue between front and back end.
module cvc_fifo #(
    parameter int W     = cvc_pkg::JOB_W,
    parameter int DEPTH = cvc_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != (PW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/cvc_back.sv =====
// Back end: result sequencer, tap selection and multiply-accumulate pipeline.
module cvc_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             job_valid,
    output logic                             job_ready,
    input  cvc_pkg::job_t                    job,
    input  logic [cvc_pkg::COEF_ROW_W-1:0]   coef_top,
    input  logic [cvc_pkg::COEF_ROW_W-1:0]   coef_mid,
    input  logic [cvc_pkg::COEF_ROW_W-1:0]   coef_bot,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_red_out,
    output logic [7:0]                       m_green_out,
    output logic [7:0]                       m_blue_out,
    output logic [7:0]                       m_alpha_out,
    output logic [10:0]                      m_out_col,
    output logic [15:0]                      m_out_row,
    output logic                             m_run_last,
    output logic                             m_frame_end
);
    localparam int PW = cvc_pkg::PROD_W;
    localparam int SW = cvc_pkg::SUM_W;

    function automatic logic [7:0] round_clamp(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        t = s + SW'(128);
        if (s < 0) begin
            return 8'd0;
        end else if (s > SW'(65280)) begin
            return 8'd255;
        end
        return t[15:8];
    endfunction

    cvc_pkg::job_t job_reg;
    logic          busy_reg;
    logic [3:0]    mask_reg, mask_in, first;
    logic          en, issue, one_left, finish, take;

    // result kinds: bit0 upper/left, bit1 upper/right, bit2 lower/left, bit3 lower/right
    always_comb begin
        mask_in[0] = (job.row != 16'd0) && (job.col != 11'd0);
        mask_in[1] = (job.row != 16'd0) && job.row_end;
        mask_in[2] = job.last_row && (job.col != 11'd0);
        mask_in[3] = job.last_row && job.row_end;
    end

    assign en        = !m_valid || m_ready;
    assign first     = mask_reg & (~mask_reg + 4'd1);
    assign one_left  = ((mask_reg & (mask_reg - 4'd1)) == 4'd0);
    assign issue     = busy_reg && (mask_reg != 4'd0) && en;
    assign finish    = busy_reg && ((mask_reg == 4'd0) || (issue && one_left));
    assign job_ready = !busy_reg || finish;
    assign take      = job_valid && job_ready;

    always_ff @(posedge aclk) begin
        if (take) begin
            job_reg <= job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mask_reg <= 4'd0;
        end else if (take) begin
            busy_reg <= 1'b1;
            mask_reg <= mask_in;
        end else if (finish) begin
            busy_reg <= 1'b0;
            mask_reg <= 4'd0;
        end else if (issue) begin
            mask_reg <= mask_reg & ~first;
        end
    end

    // tap selection
    logic            lower, right;
    logic [1:0]      rsel [3];
    logic [1:0]      csel [3];
    cvc_pkg::pixel_t taps [9];
    cvc_pkg::side_t  side_in;

    always_comb begin
        lower   = first[2] | first[3];
        right   = first[1] | first[3];
        rsel[0] = lower ? ((job_reg.row != 16'd0) ? 2'd1 : 2'd2)
                        : ((job_reg.row == 16'd1) ? 2'd1 : 2'd0);
        rsel[1] = lower ? 2'd2 : 2'd1;
        rsel[2] = 2'd2;
        csel[0] = right ? ((job_reg.col != 11'd0) ? 2'd1 : 2'd2)
                        : ((job_reg.col == 11'd1) ? 2'd1 : 2'd0);
        csel[1] = right ? 2'd2 : 2'd1;
        csel[2] = 2'd2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                taps[3*i+j] = job_reg.win[({2'b00, rsel[i]} * 4'd3) + {2'b00, csel[j]}];
            end
        end
        side_in.alpha     = taps[4][31:24];
        side_in.col       = right ? job_reg.col : job_reg.col - 11'd1;
        side_in.row       = lower ? job_reg.row : job_reg.row - 16'd1;
        side_in.run_last  = one_left;
        side_in.frame_end = first[3];
    end

    // stage 1: selected taps
    logic            p1_valid_reg;
    cvc_pkg::pixel_t p1_taps_reg [9];
    cvc_pkg::side_t  p1_side_reg;

    // stage 2: products
    logic                 p2_valid_reg;
    logic signed [PW-1:0] p2_prod_reg [3][9];
    cvc_pkg::side_t       p2_side_reg;

    // stage 3: per-row sums
    logic                 p3_valid_reg;
    logic signed [SW-1:0] p3_row_reg [3][3];
    cvc_pkg::side_t       p3_side_reg;

    // stage 4: totals
    logic                 p4_valid_reg;
    logic signed [SW-1:0] p4_sum_reg [3];
    cvc_pkg::side_t       p4_side_reg;

    logic [cvc_pkg::COEF_ROW_W-1:0] coef_rows [3];
    logic signed [cvc_pkg::COEF_W-1:0] coef [9];
    logic signed [PW-1:0] prod [3][9];

    always_comb begin
        coef_rows[0] = coef_top;
        coef_rows[1] = coef_mid;
        coef_rows[2] = coef_bot;
        for (int k = 0; k < 9; k++) begin
            coef[k] = coef_rows[k/3][(k%3)*cvc_pkg::COEF_W +: cvc_pkg::COEF_W];
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                prod[ch][k] = PW'($signed({1'b0, p1_taps_reg[k][8*ch +: 8]}) * coef[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_taps_reg  <= taps;
            p1_side_reg  <= side_in;
            p2_prod_reg  <= prod;
            p2_side_reg  <= p1_side_reg;
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 3; i++) begin
                    p3_row_reg[ch][i] <= SW'(p2_prod_reg[ch][3*i])
                                       + SW'(p2_prod_reg[ch][3*i+1])
                                       + SW'(p2_prod_reg[ch][3*i+2]);
                end
                p4_sum_reg[ch] <= p3_row_reg[ch][0] + p3_row_reg[ch][1] + p3_row_reg[ch][2];
            end
            p3_side_reg  <= p2_side_reg;
            p4_side_reg  <= p3_side_reg;
            m_red_out    <= round_clamp(p4_sum_reg[0]);
            m_green_out  <= round_clamp(p4_sum_reg[1]);
            m_blue_out   <= round_clamp(p4_sum_reg[2]);
            m_alpha_out  <= p4_side_reg.alpha;
            m_out_col    <= p4_side_reg.col;
            m_out_row    <= p4_side_reg.row;
            m_run_last   <= p4_side_reg.run_last;
            m_frame_end  <= p4_side_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            m_valid      <= p4_valid_reg;
        end
    end

endmodule

// ===== hw/rtl/convolve_3x3_edge_clamp.sv =====
// 3x3 RGB convolution with edge replication over a raster pixel stream.
// Throughput: one pixel per cycle when not back-pressured; a row end adds one extra result,
// the last row doubles them. Back end issues one result per cycle unless the output stalls;
// a 4-entry queue absorbs the row-end bursts. Requests pass front end, queue, then back end.
// Reset (aresetn, synchronous, active low): counters, window, queue and config to defaults;
// line stores are not cleared.
module convolve_3x3_edge_clamp #(
    parameter int MAX_WIDTH = cvc_pkg::MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [41:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic [7:0]  s_alpha_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic [7:0]  m_alpha_out,
    output logic [10:0] m_out_col,
    output logic [15:0] m_out_row,
    output logic        m_run_last,
    output logic        m_frame_end
);
    logic [41:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [11:0] frame_w_reg;
    logic [15:0] frame_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= cvc_pkg::COEF_TOP_RST;
            coef_mid_reg <= cvc_pkg::COEF_MID_RST;
            coef_bot_reg <= cvc_pkg::COEF_BOT_RST;
            frame_w_reg  <= cvc_pkg::FRAME_W_RST;
            frame_h_reg  <= cvc_pkg::FRAME_H_RST;
        end else if (cfg_valid) begin
            case (cvc_pkg::cfg_reg_t'(cfg_index))
                cvc_pkg::REG_COEF_TOP: coef_top_reg <= cfg_data;
                cvc_pkg::REG_COEF_MID: coef_mid_reg <= cfg_data;
                cvc_pkg::REG_COEF_BOT: coef_bot_reg <= cfg_data;
                cvc_pkg::REG_FRAME_W:  frame_w_reg  <= cfg_data[11:0];
                cvc_pkg::REG_FRAME_H:  frame_h_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    cvc_pkg::pixel_t s_pixel;
    assign s_pixel = {s_alpha_in, s_blue_in, s_green_in, s_red_in};

    logic          f_valid, f_ready, q_valid, q_ready;
    cvc_pkg::job_t f_job, q_job;

    cvc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .frame_width  (frame_w_reg),
        .frame_height (frame_h_reg),
        .job_valid    (f_valid),
        .job          (f_job),
        .job_ready    (f_ready)
    );

    cvc_fifo #(.W(cvc_pkg::JOB_W), .DEPTH(cvc_pkg::QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_job)
    );

    cvc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (q_valid),
        .job_ready   (q_ready),
        .job         (q_job),
        .coef_top    (coef_top_reg),
        .coef_mid    (coef_mid_reg),
        .coef_bot    (coef_bot_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out),
        .m_out_col   (m_out_col),
        .m_out_row   (m_out_row),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

    // bottom-right pixel closes its request's burst
    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last)
        else $error("frame_end without run_last");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !q_valid && !m_valid)
        else $error("queue or output valid after reset");

endmodule

// ===== verif/tb_convolve_3x3_edge_clamp.sv =====
// Testbench for the 3x3 edge-clamped convolution: raster frames in, checked filtered pixels out.
`timescale 1ns / 1ps

module tb_convolve_3x3_edge_clamp;

    localparam int LINE_MAX   = 2048;
    localparam int SETTLE_CYC = 20;
    localparam int STALL_MAX  = 4000;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [10:0] col;
        logic [15:0] row;
        logic        run_last;
        logic        frame_end;
    } conv_px_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [41:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_red_in, s_green_in, s_blue_in, s_alpha_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red_out, m_green_out, m_blue_out, m_alpha_out;
    logic [10:0] m_out_col;
    logic [15:0] m_out_row;
    logic        m_run_last;
    logic        m_frame_end;

    convolve_3x3_edge_clamp DUT (.*);

    // predictor copy of the block's state and registers
    logic [cvc_pkg::COEF_ROW_W-1:0] kern_row [3];
    logic [11:0]                    frame_w;
    logic [15:0]                    frame_h;
    cvc_pkg::pixel_t                line_old [LINE_MAX];
    cvc_pkg::pixel_t                line_new [LINE_MAX];
    cvc_pkg::pixel_t                win [9];
    int unsigned                    col_cnt, row_cnt;

    cvc_pkg::pixel_t pixel_queue [$];
    conv_px_t        filtered_q  [$];

    int  n_pixels, n_results, n_frames, n_cfg, n_errors, stall_cnt;
    bit  calm;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] round_clamp(longint s);
        if (s < 0) return 8'd0;
        if (s > 255 * 256) return 8'd255;
        return 8'((s + 128) >>> 8);
    endfunction

    function automatic conv_px_t filter_at(int rr[3], int cc[3], int orow, int ocol);
        conv_px_t        res;
        longint          acc [3];
        int              w;
        cvc_pkg::pixel_t p;
        acc = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p = win[rr[i] * 3 + cc[j]];
                w = int'($signed(kern_row[i][j * cvc_pkg::COEF_W +: cvc_pkg::COEF_W]));
                for (int ch = 0; ch < 3; ch++) begin
                    acc[ch] += longint'(p[8 * ch +: 8]) * w;
                end
            end
        end
        res.red       = round_clamp(acc[0]);
        res.green     = round_clamp(acc[1]);
        res.blue      = round_clamp(acc[2]);
        res.alpha     = win[rr[1] * 3 + cc[1]][31:24];
        res.col       = 11'(ocol);
        res.row       = 16'(orow);
        res.run_last  = 1'b0;
        res.frame_end = 1'b0;
        return res;
    endfunction

    function automatic void predict_pixel(cvc_pkg::pixel_t px);
        int unsigned w, h, c, r, idx;
        bit          row_end, last_row;
        int          rr [3];
        int          cc [3];
        conv_px_t    outs [$];
        w   = frame_w;
        h   = frame_h;
        c   = col_cnt;
        r   = row_cnt;
        if (w < 1) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        if (h < 1) h = 1;
        idx = (c < LINE_MAX) ? c : LINE_MAX - 1;
        for (int i = 0; i < 3; i++) begin
            win[i * 3]     = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2]        = line_old[idx];
        win[5]        = line_new[idx];
        win[8]        = px;
        line_old[idx] = line_new[idx];
        line_new[idx] = px;
        row_end  = (c >= w - 1);
        last_row = (r >= h - 1);
        if (r >= 1) begin
            rr = '{(r == 1) ? 1 : 0, 1, 2};
            if (c >= 1) begin
                cc = '{(c == 1) ? 1 : 0, 1, 2};
                outs.push_back(filter_at(rr, cc, r - 1, c - 1));
            end
            if (row_end) begin
                cc = '{(c >= 1) ? 1 : 2, 2, 2};
                outs.push_back(filter_at(rr, cc, r - 1, c));
            end
        end
        if (last_row) begin
            rr = '{(r >= 1) ? 1 : 2, 2, 2};
            if (c >= 1) begin
                cc = '{(c == 1) ? 1 : 0, 1, 2};
                outs.push_back(filter_at(rr, cc, r, c - 1));
            end
            if (row_end) begin
                cc = '{(c >= 1) ? 1 : 2, 2, 2};
                outs.push_back(filter_at(rr, cc, r, c));
            end
        end
        if (outs.size() > 0) begin
            outs[outs.size() - 1].run_last  = 1'b1;
            outs[outs.size() - 1].frame_end = last_row && row_end;
        end
        foreach (outs[k]) filtered_q.push_back(outs[k]);
        if (row_end) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_cnt = (c + 1) & 11'h7FF;
        end
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        cvc_pkg::pixel_t px;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pixel({s_alpha_in, s_blue_in, s_green_in, s_red_in});
                n_pixels++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
                    px = pixel_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_red_in   <= px[7:0];
                    s_green_in <= px[15:8];
                    s_blue_in  <= px[23:16];
                    s_alpha_in <= px[31:24];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        conv_px_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 34);
            if (m_valid && m_ready) begin
                got = '{m_red_out, m_green_out, m_blue_out, m_alpha_out,
                        m_out_col, m_out_row, m_run_last, m_frame_end};
                n_results++;
                if (got.frame_end) n_frames++;
                if (filtered_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = filtered_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic write_reg(cvc_pkg::cfg_reg_t idx, logic [41:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            cvc_pkg::REG_COEF_TOP: kern_row[0] = value;
            cvc_pkg::REG_COEF_MID: kern_row[1] = value;
            cvc_pkg::REG_COEF_BOT: kern_row[2] = value;
            cvc_pkg::REG_FRAME_W:  frame_w = value[11:0];
            cvc_pkg::REG_FRAME_H:  frame_h = value[15:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        do @(posedge aclk);
        while (pixel_queue.size() != 0 || s_valid || filtered_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_kernel(logic [41:0] top, logic [41:0] mid, logic [41:0] bot);
        write_reg(cvc_pkg::REG_COEF_TOP, top);
        write_reg(cvc_pkg::REG_COEF_MID, mid);
        write_reg(cvc_pkg::REG_COEF_BOT, bot);
    endtask

    task automatic set_frame(logic [11:0] w, logic [15:0] h);
        write_reg(cvc_pkg::REG_FRAME_W, 42'(w));
        write_reg(cvc_pkg::REG_FRAME_H, 42'(h));
    endtask

    task automatic queue_pixels(int n);
        cvc_pkg::pixel_t px;
        for (int i = 0; i < n; i++) begin
            px = $urandom;
            if ($urandom_range(7) == 0) px[7:0]   = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(7) == 0) px[15:8]  = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(7) == 0) px[23:16] = $urandom_range(1) ? 8'hFF : 8'h00;
            pixel_queue.push_back(px);
        end
    endtask

    function automatic logic [41:0] rand_kernel_row();
        logic [41:0] v;
        case ($urandom_range(3))
            0: v = 42'({$urandom, $urandom});
            default: begin
                for (int k = 0; k < 3; k++) v[k * 14 +: 14] = 14'($signed($urandom_range(600)) - 300);
            end
        endcase
        return v;
    endfunction

    initial begin
        int w, h, phase;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = cvc_pkg::REG_COEF_TOP;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_red_in   = '0;
        s_green_in = '0;
        s_blue_in  = '0;
        s_alpha_in = '0;
        m_ready    = 1'b0;
        calm       = 1'b0;
        kern_row   = '{cvc_pkg::COEF_TOP_RST, cvc_pkg::COEF_MID_RST, cvc_pkg::COEF_BOT_RST};
        frame_w    = cvc_pkg::FRAME_W_RST;
        frame_h    = cvc_pkg::FRAME_H_RST;
        foreach (line_old[i]) begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // default sharpen kernel on a small frame of saturated, zero and random pixels
        set_frame(12'd4, 16'd3);
        for (int i = 0; i < 12; i++) begin
            pixel_queue.push_back((i % 3 == 0) ? 32'hFFFF_FFFF :
                                  (i % 3 == 1) ? 32'h0000_0000 : $urandom);
        end
        settle();
        // largest coefficients, one-pixel frame; then zero sizes acting as one
        set_kernel({3{14'h1FFF}}, {3{14'h1FFF}}, {3{14'h1FFF}});
        set_frame(12'd1, 16'd1);
        queue_pixels(1);
        settle();
        set_frame(12'd0, 16'd0);
        queue_pixels(2);
        settle();
        // most negative coefficients
        set_kernel({3{14'h2000}}, {3{14'h2000}}, {3{14'h2000}});
        set_frame(12'd3, 16'd2);
        queue_pixels(6);
        settle();
        // centre weight one half: odd values land exactly on the rounding point
        set_kernel(42'd0, 42'(14'h0080) << 14, 42'd0);
        set_frame(12'd2, 16'd2);
        for (int i = 0; i < 4; i++) pixel_queue.push_back($urandom | 32'h0001_0101);
        settle();

        phase = 0;
        while (n_pixels < 380) begin
            calm = (phase >= 4 && phase < 9);
            set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
            if (phase % 6 == 0) begin
                // tall frame cut short: shrink both sizes while counters are past them
                w = $urandom_range(4, 9);
                set_frame(12'(w), 16'd65535);
                queue_pixels(3 * w + 3);
                settle();
                set_frame(12'($urandom_range(1, 3)), 16'($urandom_range(1, 3)));
                queue_pixels(1);
            end else begin
                w = $urandom_range(1, 9);
                h = $urandom_range(0, 6);
                set_frame(12'(w), 16'(h));
                queue_pixels(w * ((h == 0) ? 1 : h));
            end
            settle();
            phase++;
        end

        // width beyond the line store acts as the full width
        calm = 1'b0;
        set_frame(12'd4095, 16'd1);
        queue_pixels(40);
        settle();

        $display("Covered %0d pixels, %0d filtered results, %0d frames, %0d register writes.",
                 n_pixels, n_results, n_frames, n_cfg);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
